@@ hdl/lqrd_pkg.sv @@
// Shared constants and types for the low-quality run detector.
// No dependencies; every other file refers to this package by scoped names.
package lqrd_pkg;

    // Track limits
    localparam int REGION_LIMIT = 32;
    localparam int MAX_BITCELLS = 1048576;

    // Field widths
    localparam int Q_W      = 16;
    localparam int NORM_W   = 16;
    localparam int IDX_W    = 20;
    localparam int REGION_W = 6;
    localparam int CFG_W    = 16;

    // Internal widths
    localparam int POS_W   = $clog2(MAX_BITCELLS + 1);
    localparam int LEN_W   = 21;
    localparam int SUM_W   = 37;
    localparam int CNT_W   = $clog2(REGION_LIMIT + 1);
    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_AW    = $clog2(FIFO_DEPTH);

    // Normalization constants: (q + 10 dB) / 50 dB in Q8.8 to Q0.16
    localparam int NORM_OFFSET = 2560;
    localparam int NORM_SCALE  = 5243;
    localparam int NORM_SHIFT  = 10;

    // Configuration register indexes
    localparam logic REG_THRESHOLD = 1'b0;
    localparam logic REG_MIN_RUN   = 1'b1;

    // Reset values of the configuration registers
    localparam logic [CFG_W-1:0] THRESHOLD_RST = 16'd32768;
    localparam logic [CFG_W-1:0] MIN_RUN_RST   = 16'd16;

    // One pending result, passed from the run tracker to the divide back end
    typedef struct packed {
        logic                region_valid;
        logic [IDX_W-1:0]    start_index;
        logic [IDX_W-1:0]    end_index;
        logic [SUM_W-1:0]    run_sum;
        logic [LEN_W-1:0]    run_length;
        logic [REGION_W-1:0] region_number;
        logic                track_done;
    } desc_t;

endpackage

@@ hdl/lqrd_front.sv @@
// Front end of the run detector: normalizes samples and tracks low runs.
// Depends on lqrd_pkg; pushes result descriptors into lqrd_queue.
module lqrd_front (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic signed [lqrd_pkg::Q_W-1:0] quality_db,
    input  logic                          last_sample,
    input  logic [lqrd_pkg::CFG_W-1:0]    threshold,
    input  logic [lqrd_pkg::CFG_W-1:0]    min_run,
    output logic                          push_valid,
    input  logic                          push_ready,
    output lqrd_pkg::desc_t               push_desc
);

    localparam logic [lqrd_pkg::POS_W-1:0] MAX_POS = lqrd_pkg::POS_W'(lqrd_pkg::MAX_BITCELLS);
    localparam logic [lqrd_pkg::IDX_W-1:0] LAST_IDX =
        lqrd_pkg::IDX_W'(lqrd_pkg::MAX_BITCELLS - 1);
    localparam logic [lqrd_pkg::CNT_W-1:0] MAX_CNT = lqrd_pkg::CNT_W'(lqrd_pkg::REGION_LIMIT);

    // Stage A: normalization
    logic                        a_valid_reg;
    logic [lqrd_pkg::NORM_W-1:0] a_norm_reg;
    logic                        a_last_reg;

    logic signed [lqrd_pkg::Q_W+1:0] v_sum;
    logic [lqrd_pkg::Q_W+12:0]       prod;
    logic [lqrd_pkg::Q_W+2:0]        scaled;
    logic [lqrd_pkg::NORM_W-1:0]     norm_next;
    logic                            b_fire;

    always_comb
    begin
        v_sum  = (lqrd_pkg::Q_W+2)'(quality_db) + (lqrd_pkg::Q_W+2)'(lqrd_pkg::NORM_OFFSET);
        prod   = (lqrd_pkg::Q_W+13)'(v_sum[lqrd_pkg::Q_W-1:0]) *
                 (lqrd_pkg::Q_W+13)'(lqrd_pkg::NORM_SCALE);
        scaled = prod[lqrd_pkg::Q_W+12:lqrd_pkg::NORM_SHIFT];
        if (v_sum[lqrd_pkg::Q_W+1] || (v_sum == '0))
        begin
            norm_next = '0;
        end
        else if (scaled[lqrd_pkg::Q_W+2:lqrd_pkg::NORM_W] != '0)
        begin
            norm_next = '1;
        end
        else
        begin
            norm_next = scaled[lqrd_pkg::NORM_W-1:0];
        end
    end

    assign in_ready = !a_valid_reg || b_fire;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            a_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            a_norm_reg <= norm_next;
            a_last_reg <= last_sample;
        end
    end

    // Stage B: run tracking
    logic                        in_run_reg,   in_run_next;
    logic [lqrd_pkg::IDX_W-1:0]  start_reg,    start_next;
    logic [lqrd_pkg::LEN_W-1:0]  len_reg,      len_next;
    logic [lqrd_pkg::SUM_W-1:0]  sum_reg,      sum_next;
    logic [lqrd_pkg::POS_W-1:0]  pos_reg,      pos_next;
    logic [lqrd_pkg::CNT_W-1:0]  regions_reg,  regions_next;

    logic                        pos_ok;
    logic                        low;
    logic                        room;
    logic                        brk_emit;
    logic                        end_emit;
    logic [lqrd_pkg::IDX_W-1:0]  cur_idx;
    logic [lqrd_pkg::IDX_W-1:0]  eot_idx;
    logic [lqrd_pkg::LEN_W-1:0]  min_len;
    logic [lqrd_pkg::CNT_W+lqrd_pkg::REGION_W-1:0] regions_ext;
    lqrd_pkg::desc_t             desc;

    assign b_fire = a_valid_reg && push_ready;

    always_comb
    begin
        pos_ok      = pos_reg < MAX_POS;
        cur_idx     = pos_reg[lqrd_pkg::IDX_W-1:0];
        eot_idx     = pos_ok ? cur_idx : LAST_IDX;
        low         = {1'b0, a_norm_reg} < {1'b0, threshold};
        room        = regions_reg < MAX_CNT;
        min_len     = lqrd_pkg::LEN_W'(min_run);
        regions_ext = {{lqrd_pkg::REGION_W{1'b0}}, regions_reg};

        in_run_next  = in_run_reg;
        start_next   = start_reg;
        len_next     = len_reg;
        sum_next     = sum_reg;
        pos_next     = pos_reg;
        brk_emit     = 1'b0;

        if (pos_ok)
        begin
            pos_next = pos_reg + 1'b1;
            if (low)
            begin
                start_next  = in_run_reg ? start_reg : cur_idx;
                len_next    = (in_run_reg ? len_reg : '0) + 1'b1;
                sum_next    = (in_run_reg ? sum_reg : '0) + lqrd_pkg::SUM_W'(a_norm_reg);
                in_run_next = 1'b1;
            end
            else
            begin
                // A high sample closes the open run
                brk_emit    = (pos_reg != '0) && in_run_reg && (len_reg >= min_len) && room;
                in_run_next = 1'b0;
                len_next    = '0;
                sum_next    = '0;
            end
        end

        end_emit = a_last_reg && !brk_emit && in_run_next && (len_next >= min_len) && room;

        desc = '0;
        desc.track_done = a_last_reg;
        if (brk_emit)
        begin
            desc.region_valid  = 1'b1;
            desc.start_index   = start_reg;
            desc.end_index     = cur_idx - 1'b1;
            desc.run_sum       = sum_reg;
            desc.run_length    = len_reg;
            desc.region_number = regions_ext[lqrd_pkg::REGION_W-1:0];
        end
        else if (end_emit)
        begin
            desc.region_valid  = 1'b1;
            desc.start_index   = start_next;
            desc.end_index     = eot_idx;
            desc.run_sum       = sum_next;
            desc.run_length    = len_next;
            desc.region_number = regions_ext[lqrd_pkg::REGION_W-1:0];
        end

        regions_next = regions_reg + lqrd_pkg::CNT_W'(brk_emit || end_emit);

        // End of track: clear all per-track state
        if (a_last_reg)
        begin
            in_run_next  = 1'b0;
            start_next   = '0;
            len_next     = '0;
            sum_next     = '0;
            pos_next     = '0;
            regions_next = '0;
        end
    end

    assign push_valid = b_fire && (brk_emit || a_last_reg);
    assign push_desc  = desc;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_run_reg  <= 1'b0;
            start_reg   <= '0;
            len_reg     <= '0;
            sum_reg     <= '0;
            pos_reg     <= '0;
            regions_reg <= '0;
        end
        else if (b_fire)
        begin
            in_run_reg  <= in_run_next;
            start_reg   <= start_next;
            len_reg     <= len_next;
            sum_reg     <= sum_next;
            pos_reg     <= pos_next;
            regions_reg <= regions_next;
        end
    end

endmodule

@@ hdl/lqrd_queue.sv @@
// Short descriptor queue between the run tracker and the divide back end.
// Depends on lqrd_pkg for the descriptor type and depth.
module lqrd_queue (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push_valid,
    output logic            push_ready,
    input  lqrd_pkg::desc_t push_desc,
    output logic            pop_valid,
    input  logic            pop_ready,
    output lqrd_pkg::desc_t pop_desc
);

    lqrd_pkg::desc_t                 mem [lqrd_pkg::FIFO_DEPTH];
    logic [lqrd_pkg::FIFO_AW-1:0]    wr_ptr_reg;
    logic [lqrd_pkg::FIFO_AW-1:0]    rd_ptr_reg;
    logic [lqrd_pkg::FIFO_AW:0]      count_reg;
    logic                            do_push;
    logic                            do_pop;

    assign push_ready = count_reg != (lqrd_pkg::FIFO_AW+1)'(lqrd_pkg::FIFO_DEPTH);
    assign pop_valid  = count_reg != '0;
    assign pop_desc   = mem[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem[wr_ptr_reg] <= push_desc;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            case ({do_push, do_pop})
                2'b10:   count_reg <= count_reg + 1'b1;
                2'b01:   count_reg <= count_reg - 1'b1;
                default: count_reg <= count_reg;
            endcase
        end
    end

endmodule

@@ hdl/lqrd_back.sv @@
// Back end of the run detector: divides run sum by length, holds the result.
// Depends on lqrd_pkg; pops descriptors from lqrd_queue.
module lqrd_back (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             pop_valid,
    output logic                             pop_ready,
    input  lqrd_pkg::desc_t                  pop_desc,
    output logic                             out_valid,
    input  logic                             out_ready,
    output logic                             region_valid,
    output logic [lqrd_pkg::IDX_W-1:0]       start_index,
    output logic [lqrd_pkg::IDX_W-1:0]       end_index,
    output logic [lqrd_pkg::NORM_W-1:0]      mean_quality,
    output logic [lqrd_pkg::REGION_W-1:0]    region_number,
    output logic                             track_done
);

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_DIV  = 3'b010,
        ST_DONE = 3'b100
    } state_t;

    localparam int STEP_W = $clog2(lqrd_pkg::NORM_W);

    state_t                          state_reg, state_next;
    lqrd_pkg::desc_t                 hold_reg;
    logic [lqrd_pkg::LEN_W-1:0]      rem_reg;
    logic [lqrd_pkg::NORM_W-1:0]     dvd_reg;
    logic [lqrd_pkg::NORM_W-1:0]     quo_reg;
    logic [STEP_W-1:0]               step_reg;

    logic                            out_valid_reg;
    logic                            region_valid_reg;
    logic [lqrd_pkg::IDX_W-1:0]      start_index_reg;
    logic [lqrd_pkg::IDX_W-1:0]      end_index_reg;
    logic [lqrd_pkg::NORM_W-1:0]     avg_reg;
    logic [lqrd_pkg::REGION_W-1:0]   region_number_reg;
    logic                            track_done_reg;

    logic                            out_free;
    logic                            take_plain;
    logic                            take_region;
    logic                            load_div_out;
    logic [lqrd_pkg::LEN_W:0]        trial;
    logic [lqrd_pkg::LEN_W:0]        diff;
    logic                            q_bit;

    assign out_free     = !out_valid_reg || out_ready;
    assign take_plain   = (state_reg == ST_IDLE) && pop_valid && !pop_desc.region_valid
                          && out_free;
    assign take_region  = (state_reg == ST_IDLE) && pop_valid && pop_desc.region_valid;
    assign load_div_out = (state_reg == ST_DONE) && out_free;
    assign pop_ready    = take_plain || take_region;

    // One restoring step: shift in the next dividend bit, subtract if it fits
    always_comb
    begin
        trial = {rem_reg, dvd_reg[lqrd_pkg::NORM_W-1]};
        diff  = trial - {1'b0, hold_reg.run_length};
        q_bit = !diff[lqrd_pkg::LEN_W];
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (take_region)
                begin
                    state_next = ST_DIV;
                end
            end
            ST_DIV:
            begin
                if (step_reg == '0)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (take_plain || load_div_out)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (take_region)
        begin
            // Sum is below length * 2^16, so its upper part is already below length
            hold_reg <= pop_desc;
            rem_reg  <= pop_desc.run_sum[lqrd_pkg::SUM_W-1:lqrd_pkg::NORM_W];
            dvd_reg  <= pop_desc.run_sum[lqrd_pkg::NORM_W-1:0];
            quo_reg  <= '0;
            step_reg <= STEP_W'(lqrd_pkg::NORM_W - 1);
        end
        else if (state_reg == ST_DIV)
        begin
            rem_reg  <= q_bit ? diff[lqrd_pkg::LEN_W-1:0] : trial[lqrd_pkg::LEN_W-1:0];
            dvd_reg  <= {dvd_reg[lqrd_pkg::NORM_W-2:0], 1'b0};
            quo_reg  <= {quo_reg[lqrd_pkg::NORM_W-2:0], q_bit};
            step_reg <= step_reg - 1'b1;
        end

        if (take_plain)
        begin
            region_valid_reg  <= 1'b0;
            start_index_reg   <= '0;
            end_index_reg     <= '0;
            avg_reg           <= '0;
            region_number_reg <= '0;
            track_done_reg    <= pop_desc.track_done;
        end
        else if (load_div_out)
        begin
            region_valid_reg  <= 1'b1;
            start_index_reg   <= hold_reg.start_index;
            end_index_reg     <= hold_reg.end_index;
            avg_reg           <= quo_reg;
            region_number_reg <= hold_reg.region_number;
            track_done_reg    <= hold_reg.track_done;
        end
    end

    assign out_valid      = out_valid_reg;
    assign region_valid   = region_valid_reg;
    assign start_index    = start_index_reg;
    assign end_index      = end_index_reg;
    assign mean_quality   = avg_reg;
    assign region_number  = region_number_reg;
    assign track_done     = track_done_reg;

endmodule

@@ hdl/low_quality_run_detector.sv @@
// Top level of the low-quality run detector: APB registers and the three parts.
// Depends on lqrd_pkg, lqrd_front, lqrd_queue and lqrd_back.
//
// Feed one bitcell quality sample (signed Q8.8 dB) per item; mark the final
// sample of a track with last_sample. Each sample is mapped to a Q0.16
// confidence, and runs of samples below threshold are tracked. A run of at
// least min_run samples yields one result item when a sample at or above
// threshold ends it, or at the end of the track; the last sample always yields
// a result with track_done set, and per-track state is then cleared. At most
// 32 regions are reported per track, and samples beyond index 1048575 are
// dropped. The front end takes one item per cycle while the queue has room,
// passing it through its normalize and track stages. Each reported region
// is handed to the back end, where a restoring divider works out the average
// one quotient bit per cycle, one region at a time. A four-entry queue
// between the two absorbs bursts, so input stalls only when regions come
// faster than the divider can drain them or when results back up at the
// output. Write threshold at byte address 0 and min_run at byte address 4,
// only while the block is idle.
module low_quality_run_detector (
    input  logic                               clk,
    input  logic                               rst_n,
    // Sample input
    input  logic                               in_valid,
    output logic                               in_ready,
    input  logic signed [lqrd_pkg::Q_W-1:0]    quality_db,
    input  logic                               last_sample,
    // Result output
    output logic                               out_valid,
    input  logic                               out_ready,
    output logic                               region_valid,
    output logic [lqrd_pkg::IDX_W-1:0]         start_index,
    output logic [lqrd_pkg::IDX_W-1:0]         end_index,
    output logic [lqrd_pkg::NORM_W-1:0]        mean_quality,
    output logic [lqrd_pkg::REGION_W-1:0]      region_number,
    output logic                               track_done,
    // Configuration
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [2:0]                         paddr,
    input  logic [31:0]                        pwdata,
    output logic [31:0]                        prdata,
    output logic                               pready
);

    logic [lqrd_pkg::CFG_W-1:0] threshold_reg;
    logic [lqrd_pkg::CFG_W-1:0] min_run_reg;
    logic                       cfg_write;
    logic                       reg_sel;

    // Registers are word aligned; bit 2 picks the register
    assign reg_sel   = paddr[2];
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            threshold_reg <= lqrd_pkg::THRESHOLD_RST;
            min_run_reg   <= lqrd_pkg::MIN_RUN_RST;
        end
        else if (cfg_write)
        begin
            unique case (reg_sel)
                lqrd_pkg::REG_THRESHOLD: threshold_reg <= pwdata[lqrd_pkg::CFG_W-1:0];
                lqrd_pkg::REG_MIN_RUN:   min_run_reg   <= pwdata[lqrd_pkg::CFG_W-1:0];
                default:                 threshold_reg <= threshold_reg;
            endcase
        end
    end

    // Read back, ignoring the low address bits and paddr[1:0]
    always_comb
    begin
        unique case (reg_sel)
            lqrd_pkg::REG_THRESHOLD: prdata = {16'h0000, threshold_reg};
            lqrd_pkg::REG_MIN_RUN:   prdata = {16'h0000, min_run_reg};
            default:                 prdata = '0;
        endcase
    end

    // Front end to queue
    logic            push_valid;
    logic            push_ready;
    lqrd_pkg::desc_t push_desc;

    // Queue to back end
    logic            pop_valid;
    logic            pop_ready;
    lqrd_pkg::desc_t pop_desc;

    lqrd_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .quality_db (quality_db),
        .last_sample(last_sample),
        .threshold  (threshold_reg),
        .min_run    (min_run_reg),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_desc  (push_desc)
    );

    lqrd_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_desc  (push_desc),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_desc   (pop_desc)
    );

    lqrd_back u_back (
        .clk            (clk),
        .rst_n          (rst_n),
        .pop_valid      (pop_valid),
        .pop_ready      (pop_ready),
        .pop_desc       (pop_desc),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .region_valid   (region_valid),
        .start_index    (start_index),
        .end_index      (end_index),
        .mean_quality   (mean_quality),
        .region_number  (region_number),
        .track_done     (track_done)
    );

endmodule
